FILE: rtl/core/cmt_pkg.sv
// Shared types and constants for the normalization cube map texel generator.
`timescale 1ns / 1ps
package cmt_pkg;

    localparam int MAX_FACE_SIZE_DEF = 1024;
    localparam int FRAC_BITS         = 16;
    localparam int MAG_W             = FRAC_BITS + 1;
    localparam int LEN2_W            = 34;
    localparam int ROOT_STEPS        = 32;
    localparam int ROOT_W            = 31;
    localparam int RECIP_STEPS       = 31;
    localparam int RECIP_W           = 31;
    localparam int CFG_W             = 11;
    localparam logic [MAG_W-1:0] ONE_Q16 = MAG_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Carried alongside the two centre-coordinate dividers
    typedef struct packed {
        logic       bad;
        logic [2:0] face;
        logic       neg_s;
        logic       neg_t;
    } div_tag_t;

    // Carried alongside the root and reciprocal chains
    typedef struct packed {
        logic             bad;
        logic             neg_x;
        logic             neg_y;
        logic             neg_z;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] mag_z;
    } vec_tag_t;

endpackage

FILE: rtl/core/cmt_div_cell.sv
// One restoring-division step for the s and t centre coordinates.
`timescale 1ns / 1ps
module cmt_div_cell #(
    parameter int NW = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  cmt_pkg::div_tag_t                 in_tag,
    input  logic [NW-1:0]                     in_n,
    input  logic [NW-1:0]                     in_rem_s,
    input  logic [NW-1:0]                     in_rem_t,
    input  logic [cmt_pkg::FRAC_BITS-1:0]     in_quo_s,
    input  logic [cmt_pkg::FRAC_BITS-1:0]     in_quo_t,
    output logic                              out_valid,
    output cmt_pkg::div_tag_t                 out_tag,
    output logic [NW-1:0]                     out_n,
    output logic [NW-1:0]                     out_rem_s,
    output logic [NW-1:0]                     out_rem_t,
    output logic [cmt_pkg::FRAC_BITS-1:0]     out_quo_s,
    output logic [cmt_pkg::FRAC_BITS-1:0]     out_quo_t
);
    import cmt_pkg::*;

    logic                 valid_reg;
    div_tag_t             tag_reg;
    logic [NW-1:0]        n_reg;
    logic [NW-1:0]        rem_s_reg, rem_s_next;
    logic [NW-1:0]        rem_t_reg, rem_t_next;
    logic [FRAC_BITS-1:0] quo_s_reg, quo_s_next;
    logic [FRAC_BITS-1:0] quo_t_reg, quo_t_next;
    logic [NW:0]          dbl_s, dbl_t, diff_s, diff_t;
    logic                 ge_s, ge_t;

    always_comb
    begin
        dbl_s      = {in_rem_s, 1'b0};
        dbl_t      = {in_rem_t, 1'b0};
        diff_s     = dbl_s - {1'b0, in_n};
        diff_t     = dbl_t - {1'b0, in_n};
        ge_s       = dbl_s >= {1'b0, in_n};
        ge_t       = dbl_t >= {1'b0, in_n};
        rem_s_next = ge_s ? diff_s[NW-1:0] : dbl_s[NW-1:0];
        rem_t_next = ge_t ? diff_t[NW-1:0] : dbl_t[NW-1:0];
        quo_s_next = {in_quo_s[FRAC_BITS-2:0], ge_s};
        quo_t_next = {in_quo_t[FRAC_BITS-2:0], ge_t};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg   <= in_tag;
            n_reg     <= in_n;
            rem_s_reg <= rem_s_next;
            rem_t_reg <= rem_t_next;
            quo_s_reg <= quo_s_next;
            quo_t_reg <= quo_t_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_n     = n_reg;
    assign out_rem_s = rem_s_reg;
    assign out_rem_t = rem_t_reg;
    assign out_quo_s = quo_s_reg;
    assign out_quo_t = quo_t_reg;

endmodule

FILE: rtl/core/cmt_sqrt_cell.sv
// One digit step of the bit-by-bit integer square root.
`timescale 1ns / 1ps
module cmt_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cmt_pkg::vec_tag_t in_tag,
    input  logic [63:0]       in_rad,
    input  logic [63:0]       in_root,
    output logic              out_valid,
    output cmt_pkg::vec_tag_t out_tag,
    output logic [63:0]       out_rad,
    output logic [63:0]       out_root
);
    import cmt_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic        valid_reg;
    vec_tag_t    tag_reg;
    logic [63:0] rad_reg, rad_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] trial;

    always_comb
    begin
        trial = in_root + BIT;
        if (in_rad >= trial)
        begin
            rad_next  = in_rad - trial;
            root_next = (in_root >> 1) + BIT;
        end
        else
        begin
            rad_next  = in_rad;
            root_next = in_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg  <= in_tag;
            rad_reg  <= rad_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_rad   = rad_reg;
    assign out_root  = root_reg;

endmodule

FILE: rtl/core/cmt_recip_cell.sv
// One restoring-division step of the reciprocal 2^60 / length.
`timescale 1ns / 1ps
module cmt_recip_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  cmt_pkg::vec_tag_t             in_tag,
    input  logic [cmt_pkg::ROOT_W-1:0]    in_div,
    input  logic [cmt_pkg::ROOT_W-1:0]    in_rem,
    input  logic [cmt_pkg::RECIP_W-1:0]   in_quo,
    output logic                          out_valid,
    output cmt_pkg::vec_tag_t             out_tag,
    output logic [cmt_pkg::ROOT_W-1:0]    out_div,
    output logic [cmt_pkg::ROOT_W-1:0]    out_rem,
    output logic [cmt_pkg::RECIP_W-1:0]   out_quo
);
    import cmt_pkg::*;

    logic               valid_reg;
    vec_tag_t           tag_reg;
    logic [ROOT_W-1:0]  div_reg;
    logic [ROOT_W-1:0]  rem_reg, rem_next;
    logic [RECIP_W-1:0] quo_reg, quo_next;
    logic [ROOT_W:0]    dbl, diff;
    logic               ge;

    always_comb
    begin
        dbl      = {in_rem, 1'b0};
        diff     = dbl - {1'b0, in_div};
        ge       = dbl >= {1'b0, in_div};
        rem_next = ge ? diff[ROOT_W-1:0] : dbl[ROOT_W-1:0];
        quo_next = {in_quo[RECIP_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= in_tag;
            div_reg <= in_div;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_div   = div_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

FILE: rtl/core/cmt_encode.sv
// Scale each component by the reciprocal length and encode it as a byte.
`timescale 1ns / 1ps
module cmt_encode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  cmt_pkg::vec_tag_t           in_tag,
    input  logic [cmt_pkg::RECIP_W-1:0] in_rs,
    output logic                        out_valid,
    output logic [23:0]                 out_bytes,
    output logic                        out_bad
);
    import cmt_pkg::*;

    localparam int PROD_W = MAG_W + RECIP_W;

    logic              pvalid_reg;
    logic              pbad_reg;
    logic [2:0]        pneg_reg;
    logic [PROD_W-1:0] prod_reg [3];
    logic [PROD_W-1:0] prod_next [3];
    logic [MAG_W-1:0]  mag [3];
    logic              ovalid_reg;
    logic              obad_reg;
    logic [23:0]       bytes_reg, bytes_next;
    logic [25:0]       scaled [3];
    logic [25:0]       biased [3];
    logic [33:0]       times255 [3];

    always_comb
    begin
        mag[0] = in_tag.mag_x;
        mag[1] = in_tag.mag_y;
        mag[2] = in_tag.mag_z;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PROD_W'(mag[i]) * PROD_W'(in_rs);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled[i] = prod_reg[i][PROD_W-1:22];
            // saturate at unit length
            if (scaled[i] > 26'(ONE_Q16) << 8)
            begin
                scaled[i] = 26'(ONE_Q16) << 8;
            end
            biased[i] = pneg_reg[i] ? ((26'(ONE_Q16) << 8) - scaled[i])
                                    : ((26'(ONE_Q16) << 8) + scaled[i]);
            times255[i] = ({8'd0, biased[i]} << 8) - {8'd0, biased[i]};
            bytes_next[i*8 +: 8] = pbad_reg ? 8'd0 : times255[i][32:25];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else if (en)
        begin
            pvalid_reg <= in_valid;
            ovalid_reg <= pvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pbad_reg  <= in_tag.bad;
            pneg_reg  <= {in_tag.neg_z, in_tag.neg_y, in_tag.neg_x};
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            obad_reg  <= pbad_reg;
            bytes_reg <= bytes_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_bytes = bytes_reg;
    assign out_bad   = obad_reg;

endmodule

FILE: rtl/core/normalization_cube_map_texel.sv
// Top level of the normalization cube map texel generator.
//
//  port group   dir  payload                                   transfer when
//  s_*          in   tdata: face[2:0] col[12:3] row[22:13]     s_tvalid & s_tready
//  m_*          out  tdata: red[7:0] green[15:8] blue[23:16]   m_tvalid & m_tready
//                    tuser: bad_coord
//  cfg_*        in   face_size[10:0]                           cfg_we
//
// One texel per clock unless the output stalls; each passes 16 division cells for the
// centre coordinates, 32 square-root cells and 31 reciprocal cells.
// Reset clears every stage valid bit and loads face_size with 32.
// The whole chain advances together whenever the output register is empty
// or its result is taken, so a waiting result stalls every cell.
`timescale 1ns / 1ps
module normalization_cube_map_texel #(
    parameter int MAX_FACE_SIZE = cmt_pkg::MAX_FACE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,   // face_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // face[2:0], col[12:3], row[22:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // red[7:0], green[15:8], blue[23:16]
    output logic        m_tuser     // bad_coord
);
    import cmt_pkg::*;

    localparam int NW = $clog2(MAX_FACE_SIZE + 1);
    localparam int CW = (NW > CFG_W) ? NW : CFG_W;
    localparam int SW = CW + 2;

    logic              en;
    logic [CFG_W-1:0]  face_size_reg;
    logic [CW-1:0]     size_full;
    logic [NW-1:0]     size_n;
    logic [2:0]        in_face;
    logic [9:0]        in_col, in_row;
    logic signed [SW-1:0] num_s, num_t;
    logic [SW-1:0]     abs_s, abs_t;
    div_tag_t          front_tag;

    // division chain, stage 0 is the front register
    logic                 d_valid [0:FRAC_BITS];
    div_tag_t             d_tag   [0:FRAC_BITS];
    logic [NW-1:0]        d_n     [0:FRAC_BITS];
    logic [NW-1:0]        d_rs    [0:FRAC_BITS];
    logic [NW-1:0]        d_rt    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] d_qs    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] d_qt    [0:FRAC_BITS];

    logic     front_valid_reg;
    div_tag_t front_tag_reg;
    logic [NW-1:0] front_n_reg, front_rs_reg, front_rt_reg;

    vec_tag_t vec_next;
    logic     vec_valid_reg, sq_valid_reg, len_valid_reg;
    vec_tag_t vec_tag_reg, sq_tag_reg, len_tag_reg;
    logic [2*MAG_W-2:0] sq_reg [3];
    logic [LEN2_W-1:0]  len2_reg;

    logic        r_valid [0:ROOT_STEPS];
    vec_tag_t    r_tag   [0:ROOT_STEPS];
    logic [63:0] r_rad   [0:ROOT_STEPS];
    logic [63:0] r_root  [0:ROOT_STEPS];

    logic               c_valid [0:RECIP_STEPS];
    vec_tag_t           c_tag   [0:RECIP_STEPS];
    logic [ROOT_W-1:0]  c_div   [0:RECIP_STEPS];
    logic [ROOT_W-1:0]  c_rem   [0:RECIP_STEPS];
    logic [RECIP_W-1:0] c_quo   [0:RECIP_STEPS];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg <= CFG_W'(32);
        end
        else if (cfg_we)
        begin
            face_size_reg <= cfg_data;
        end
    end

    // front: clamp the size, flag bad texels and form |2p+1-n|
    always_comb
    begin
        in_face   = s_tdata[2:0];
        in_col    = s_tdata[12:3];
        in_row    = s_tdata[22:13];
        size_full = CW'(face_size_reg);
        if (size_full > CW'(MAX_FACE_SIZE))
        begin
            size_full = CW'(MAX_FACE_SIZE);
        end
        size_n = size_full[NW-1:0];
        num_s  = signed'(SW'({in_col, 1'b1})) - signed'(SW'(size_full));
        num_t  = signed'(SW'({in_row, 1'b1})) - signed'(SW'(size_full));
        abs_s  = num_s[SW-1] ? SW'(-num_s) : SW'(num_s);
        abs_t  = num_t[SW-1] ? SW'(-num_t) : SW'(num_t);
        front_tag.bad   = (in_face > 3'(FACE_NEG_Z)) || (CW'(in_col) >= size_full)
                          || (CW'(in_row) >= size_full);
        front_tag.face  = in_face;
        front_tag.neg_s = num_s[SW-1];
        front_tag.neg_t = num_t[SW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_tag_reg <= front_tag;
            front_n_reg   <= size_n;
            front_rs_reg  <= abs_s[NW-1:0];
            front_rt_reg  <= abs_t[NW-1:0];
        end
    end

    assign d_valid[0] = front_valid_reg;
    assign d_tag[0]   = front_tag_reg;
    assign d_n[0]     = front_n_reg;
    assign d_rs[0]    = front_rs_reg;
    assign d_rt[0]    = front_rt_reg;
    assign d_qs[0]    = '0;
    assign d_qt[0]    = '0;

    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        cmt_div_cell #(
            .NW (NW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d_valid[i]),
            .in_tag    (d_tag[i]),
            .in_n      (d_n[i]),
            .in_rem_s  (d_rs[i]),
            .in_rem_t  (d_rt[i]),
            .in_quo_s  (d_qs[i]),
            .in_quo_t  (d_qt[i]),
            .out_valid (d_valid[i+1]),
            .out_tag   (d_tag[i+1]),
            .out_n     (d_n[i+1]),
            .out_rem_s (d_rs[i+1]),
            .out_rem_t (d_rt[i+1]),
            .out_quo_s (d_qs[i+1]),
            .out_quo_t (d_qt[i+1])
        );
    end

    // place s, t and the unit axis by face
    always_comb
    begin
        logic [MAG_W-1:0] ms, mt;
        logic             ns, nt;
        ms = MAG_W'(d_qs[FRAC_BITS]);
        mt = MAG_W'(d_qt[FRAC_BITS]);
        ns = d_tag[FRAC_BITS].neg_s;
        nt = d_tag[FRAC_BITS].neg_t;
        vec_next.bad = d_tag[FRAC_BITS].bad;
        unique case (face_t'(d_tag[FRAC_BITS].face))
            FACE_POS_X:
            begin
                vec_next.neg_x = 1'b0; vec_next.mag_x = ONE_Q16;
                vec_next.neg_y = !nt;  vec_next.mag_y = mt;
                vec_next.neg_z = !ns;  vec_next.mag_z = ms;
            end
            FACE_NEG_X:
            begin
                vec_next.neg_x = 1'b1; vec_next.mag_x = ONE_Q16;
                vec_next.neg_y = !nt;  vec_next.mag_y = mt;
                vec_next.neg_z = ns;   vec_next.mag_z = ms;
            end
            FACE_POS_Y:
            begin
                vec_next.neg_x = ns;   vec_next.mag_x = ms;
                vec_next.neg_y = 1'b0; vec_next.mag_y = ONE_Q16;
                vec_next.neg_z = nt;   vec_next.mag_z = mt;
            end
            FACE_NEG_Y:
            begin
                vec_next.neg_x = ns;   vec_next.mag_x = ms;
                vec_next.neg_y = 1'b1; vec_next.mag_y = ONE_Q16;
                vec_next.neg_z = !nt;  vec_next.mag_z = mt;
            end
            FACE_POS_Z:
            begin
                vec_next.neg_x = ns;   vec_next.mag_x = ms;
                vec_next.neg_y = !nt;  vec_next.mag_y = mt;
                vec_next.neg_z = 1'b0; vec_next.mag_z = ONE_Q16;
            end
            default:
            begin
                vec_next.neg_x = !ns;  vec_next.mag_x = ms;
                vec_next.neg_y = !nt;  vec_next.mag_y = mt;
                vec_next.neg_z = 1'b1; vec_next.mag_z = ONE_Q16;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            len_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vec_valid_reg <= d_valid[FRAC_BITS];
            sq_valid_reg  <= vec_valid_reg;
            len_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_tag_reg <= vec_next;
            sq_tag_reg  <= vec_tag_reg;
            sq_reg[0]   <= (2*MAG_W-1)'(vec_tag_reg.mag_x) * (2*MAG_W-1)'(vec_tag_reg.mag_x);
            sq_reg[1]   <= (2*MAG_W-1)'(vec_tag_reg.mag_y) * (2*MAG_W-1)'(vec_tag_reg.mag_y);
            sq_reg[2]   <= (2*MAG_W-1)'(vec_tag_reg.mag_z) * (2*MAG_W-1)'(vec_tag_reg.mag_z);
            len_tag_reg <= sq_tag_reg;
            len2_reg    <= LEN2_W'(sq_reg[0]) + LEN2_W'(sq_reg[1]) + LEN2_W'(sq_reg[2]);
        end
    end

    assign r_valid[0] = len_valid_reg;
    assign r_tag[0]   = len_tag_reg;
    assign r_rad[0]   = {2'b00, len2_reg, 28'd0};
    assign r_root[0]  = '0;

    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_sqrt
        cmt_sqrt_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (r_valid[i]),
            .in_tag    (r_tag[i]),
            .in_rad    (r_rad[i]),
            .in_root   (r_root[i]),
            .out_valid (r_valid[i+1]),
            .out_tag   (r_tag[i+1]),
            .out_rad   (r_rad[i+1]),
            .out_root  (r_root[i+1])
        );
    end

    // length is at least 2^30 in Q.30, so 2^29 starts below the divisor
    assign c_valid[0] = r_valid[ROOT_STEPS];
    assign c_tag[0]   = r_tag[ROOT_STEPS];
    assign c_div[0]   = r_root[ROOT_STEPS][ROOT_W-1:0];
    assign c_rem[0]   = ROOT_W'(1) << (ROOT_W - 2);
    assign c_quo[0]   = '0;

    for (genvar i = 0; i < RECIP_STEPS; i++)
    begin : g_recip
        cmt_recip_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_tag    (c_tag[i]),
            .in_div    (c_div[i]),
            .in_rem    (c_rem[i]),
            .in_quo    (c_quo[i]),
            .out_valid (c_valid[i+1]),
            .out_tag   (c_tag[i+1]),
            .out_div   (c_div[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_quo   (c_quo[i+1])
        );
    end

    cmt_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid[RECIP_STEPS]),
        .in_tag    (c_tag[RECIP_STEPS]),
        .in_rs     (c_quo[RECIP_STEPS]),
        .out_valid (m_tvalid),
        .out_bytes (m_tdata),
        .out_bad   (m_tuser)
    );

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("bad texel with non-zero bytes");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid[ROOT_STEPS] && !r_tag[ROOT_STEPS].bad |-> r_root[ROOT_STEPS][ROOT_W-1])
        else $error("vector length below one");

    a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[RECIP_STEPS] && !c_tag[RECIP_STEPS].bad
        |-> c_quo[RECIP_STEPS][RECIP_W-1:RECIP_W-2] != 2'b00)
        else $error("reciprocal length out of range");

    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(d_valid[FRAC_BITS]) && $stable(c_valid[RECIP_STEPS]))
        else $error("chain moved while stalled");

endmodule
